[design/amd_pkg.sv]
// Shared types, constants and codes for the accelerometer motion detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package amd_pkg;

	// Field widths
	localparam int RawW    = 16;
	localparam int MgW     = 12;
	localparam int TimeW   = 32;
	localparam int ThrW    = 12;
	localparam int IntvW   = 16;
	localparam int CfgW    = 16;
	localparam int CfgIdxW = 2;
	localparam int StatusW = 2;

	// raw * MgScale / RawFullScale gives milli-g
	localparam int MgScale     = 2000;
	localparam int RawFullScale = 32768;
	localparam int RawShift    = $clog2(RawFullScale);
	localparam int ProdW       = RawW + $clog2(MgScale) + 1;

	// Result status codes
	typedef enum logic [StatusW-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_READ_ERR = 2'd1,
		STATUS_BAD_CFG  = 2'd2
	} status_t;

	// Register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_THRESHOLD  = 2'd0,
		REG_HYSTERESIS = 2'd1,
		REG_INTERVAL   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [ThrW-1:0]  threshold;
		logic [ThrW-1:0]  hysteresis;
		logic [IntvW-1:0] interval;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0]      uptime;
		logic signed [RawW-1:0] x;
		logic signed [RawW-1:0] y;
		logic signed [RawW-1:0] z;
		logic                   read_failed;
	} item_t;

	typedef struct packed {
		logic                  has_ref;
		logic signed [MgW-1:0] ref_x;
		logic signed [MgW-1:0] ref_y;
		logic signed [MgW-1:0] ref_z;
		logic [TimeW-1:0]      ref_time;
		logic                  motion;
	} track_state_t;

	typedef struct packed {
		logic    motion;
		status_t status;
		logic    sample_taken;
	} result_t;

endpackage

`default_nettype wire

[design/amd_mg_conv.sv]
// One-axis converter: raw 16-bit sample to signed milli-g, truncated toward zero.
// Depends on amd_pkg.
`default_nettype none

module amd_mg_conv (
	input  wire logic signed [amd_pkg::RawW-1:0] raw,
	output logic signed [amd_pkg::MgW-1:0]       mg
);
	import amd_pkg::*;

	logic signed [ProdW-1:0] prod;
	logic signed [ProdW-1:0] biased;

	// scale, then bias negatives so the shift truncates toward zero
	always_comb begin
		prod   = ProdW'(raw) * ProdW'(MgScale);
		biased = prod + (prod[ProdW-1] ? ProdW'(RawFullScale - 1) : ProdW'(0));
		mg     = MgW'(biased >>> RawShift);
	end

endmodule

`default_nettype wire

[design/amd_decide.sv]
// Decision: config check, interval gate, read error, per-axis hysteresis compare.
// Depends on amd_pkg and amd_mg_conv.
`default_nettype none

module amd_decide (
	input  wire amd_pkg::item_t        item,
	input  wire amd_pkg::track_state_t state_cur,
	input  wire amd_pkg::cfg_t         cfg,
	output amd_pkg::track_state_t      state_nxt,
	output amd_pkg::result_t           result
);
	import amd_pkg::*;

	logic signed [MgW-1:0] x_mg, y_mg, z_mg;
	logic [MgW-1:0]        dx, dy, dz;
	logic [TimeW-1:0]      elapsed;
	logic [ThrW-1:0]       clr_lvl;
	logic                  bad_cfg, too_soon, hit, calm, motion_new;

	function automatic logic [MgW-1:0] abs_diff(input logic signed [MgW-1:0] a,
			input logic signed [MgW-1:0] b);
		logic signed [MgW:0] d;
		d = (MgW+1)'(a) - (MgW+1)'(b);
		return d[MgW] ? MgW'(-d) : MgW'(d);
	endfunction

	amd_mg_conv u_conv_x (.raw(item.x), .mg(x_mg));
	amd_mg_conv u_conv_y (.raw(item.y), .mg(y_mg));
	amd_mg_conv u_conv_z (.raw(item.z), .mg(z_mg));

	// gates and compares
	always_comb begin
		bad_cfg  = cfg.hysteresis >= cfg.threshold;
		elapsed  = item.uptime - state_cur.ref_time;
		too_soon = state_cur.has_ref && (cfg.interval != '0)
			&& (elapsed < TimeW'(cfg.interval));
		dx       = abs_diff(x_mg, state_cur.ref_x);
		dy       = abs_diff(y_mg, state_cur.ref_y);
		dz       = abs_diff(z_mg, state_cur.ref_z);
		clr_lvl  = cfg.threshold - cfg.hysteresis;
		hit      = (dx >= cfg.threshold) || (dy >= cfg.threshold) || (dz >= cfg.threshold);
		calm     = (dx < clr_lvl) && (dy < clr_lvl) && (dz < clr_lvl);
	end

	// result and next tracking state, in priority order
	always_comb begin
		state_nxt           = state_cur;
		result.motion       = state_cur.motion;
		result.status       = STATUS_OK;
		result.sample_taken = 1'b0;
		motion_new          = state_cur.motion;
		if (bad_cfg) begin
			result.status = STATUS_BAD_CFG;
		end else if (too_soon) begin
			result.status = STATUS_OK;
		end else if (item.read_failed) begin
			result.status = STATUS_READ_ERR;
		end else begin
			if (!state_cur.has_ref) begin
				motion_new = 1'b0;
			end else if (hit) begin
				motion_new = 1'b1;
			end else if (calm) begin
				motion_new = 1'b0;
			end
			state_nxt.has_ref   = 1'b1;
			state_nxt.ref_x     = x_mg;
			state_nxt.ref_y     = y_mg;
			state_nxt.ref_z     = z_mg;
			state_nxt.ref_time  = item.uptime;
			state_nxt.motion    = motion_new;
			result.motion       = motion_new;
			result.sample_taken = 1'b1;
		end
	end

endmodule

`default_nettype wire

[design/accel_motion_detector_hysteresis.sv]
// Top level of the accelerometer motion detector: input stage, tracking state,
// config registers and output register. Depends on amd_pkg and amd_decide.
//
//   port group  dir  handshake           payload
//   in          in   in_valid/in_ready   stamp_ms, x_raw, y_raw, z_raw, read_failed
//   out         out  out_valid/out_ready motion, status, sample_taken
//   cfg         in   cfg_we (no wait)    cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_ready stays high. Each accepted input beat
// is registered in the input stage, then its result in the output register.
// The input stage is evaluated combinationally against the tracking state; state and
// result register update on the same edge, so the next beat sees the new state.
// A stalled result holds in the output register; the input stage still takes a
// beat while it is empty, then waits until the output frees.
// Reset clears valids, tracking state and config to their defaults; no clearing pass.
`default_nettype none

module accel_motion_detector_hysteresis (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [amd_pkg::TimeW-1:0]         stamp_ms,
	input  wire logic signed [amd_pkg::RawW-1:0]   x_raw,
	input  wire logic signed [amd_pkg::RawW-1:0]   y_raw,
	input  wire logic signed [amd_pkg::RawW-1:0]   z_raw,
	input  wire logic                              read_failed,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   motion,
	output logic [amd_pkg::StatusW-1:0]            status,
	output logic                                   sample_taken,
	input  wire logic                              cfg_we,
	input  wire logic [amd_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [amd_pkg::CfgW-1:0]          cfg_wdata
);
	import amd_pkg::*;

	item_t        item_s1;
	logic         valid_s1;
	track_state_t state_q, state_nxt;
	cfg_t         cfg_q;
	result_t      result_nxt, result_q;
	logic         out_valid_q;
	logic         advance;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign motion       = result_q.motion;
	assign status       = StatusW'(result_q.status);
	assign sample_taken = result_q.sample_taken;

	amd_decide u_decide (
		.item      (item_s1),
		.state_cur (state_q),
		.cfg       (cfg_q),
		.state_nxt (state_nxt),
		.result    (result_nxt)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{uptime: stamp_ms, x: x_raw, y: y_raw, z: z_raw,
				read_failed: read_failed};
		end
	end

	// tracking state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= ThrW'(100);
			cfg_q.hysteresis <= ThrW'(20);
			cfg_q.interval   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:  cfg_q.threshold  <= cfg_wdata[ThrW-1:0];
				REG_HYSTERESIS: cfg_q.hysteresis <= cfg_wdata[ThrW-1:0];
				REG_INTERVAL:   cfg_q.interval   <= cfg_wdata[IntvW-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/amd_checker.sv]
// Port-level checks for the motion detector, bound to the top level.
// Depends on amd_pkg.
`default_nettype none

module amd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          motion,
	input wire logic [amd_pkg::StatusW-1:0]   status,
	input wire logic                          sample_taken
);
	import amd_pkg::*;

	logic last_motion_q;

	// motion reported by the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_motion_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_motion_q <= motion;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(motion) && $stable(status) && $stable(sample_taken))
		else $error("result payload changed while stalled");

	a_err_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> !sample_taken)
		else $error("error status on an evaluated sample");

	a_skip_holds_motion: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_taken |-> motion == last_motion_q)
		else $error("motion changed on a skipped or failed beat");

endmodule

bind accel_motion_detector_hysteresis amd_checker u_amd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.motion       (motion),
	.status       (status),
	.sample_taken (sample_taken)
);

`default_nettype wire

[tb/sv/tb_accel_motion_detector_hysteresis.sv]
// Self-checking testbench for accel_motion_detector_hysteresis: directed probes,
// then random phases under changing thresholds, intervals and handshake stalls.
// Depends on amd_pkg and the design top level; stands alone otherwise.
`timescale 1ns / 1ps

module tb_accel_motion_detector_hysteresis;
	import amd_pkg::*;

	localparam int NumProbes     = 24;
	localparam int NumPhases     = 8;
	localparam int PhaseBeats    = 200;
	localparam int HoldOffCycles = 300;
	localparam int SettleCycles  = 6;
	localparam int CycleLimit    = 200000;
	localparam int MaxReports    = 10;
	// index past the last register; writes to it must do nothing
	localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

	typedef struct {
		int          thr;
		int          hyst;
		int          intv;
		logic [31:0] t;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        fail;
		bit          typed;
		logic        motion;
		status_t     status;
		logic        taken;
	} probe_row_t;

	logic                       clk;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_ready;
	logic [TimeW-1:0]           stamp_ms    = '0;
	logic signed [RawW-1:0]     x_raw       = '0;
	logic signed [RawW-1:0]     y_raw       = '0;
	logic signed [RawW-1:0]     z_raw       = '0;
	logic                       read_failed = 1'b0;
	logic                       out_valid;
	logic                       out_ready   = 1'b0;
	logic                       motion;
	logic [StatusW-1:0]         status;
	logic                       sample_taken;
	logic                       cfg_we      = 1'b0;
	logic [CfgIdxW-1:0]         cfg_index   = '0;
	logic [CfgW-1:0]            cfg_wdata   = '0;

	accel_motion_detector_hysteresis u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.stamp_ms(stamp_ms), .x_raw(x_raw), .y_raw(y_raw), .z_raw(z_raw),
		.read_failed(read_failed),
		.out_valid(out_valid), .out_ready(out_ready),
		.motion(motion), .status(status), .sample_taken(sample_taken),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the registers and the tracking state
	int          lim_thr  = 100;
	int          lim_hyst = 20;
	int          lim_intv = 0;
	bit          trk_has_ref = 1'b0;
	int          trk_x = 0, trk_y = 0, trk_z = 0;
	logic [31:0] trk_time = '0;
	logic        trk_motion = 1'b0;

	result_t     motion_verdicts [$];
	int          err_count = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_off_reqs = 0;
	int          hold_off_seen = 0;
	int          hold_left = 0;
	probe_row_t  probes [NumProbes];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// raw count to milli-g, truncated toward zero
	function automatic int to_mg(logic signed [15:0] raw);
		return (int'(raw) * MgScale) / RawFullScale;
	endfunction

	function automatic int magnitude(int d);
		return (d < 0) ? -d : d;
	endfunction

	// Expected result of one beat; advances the tracking state
	function automatic result_t judge_motion(logic [31:0] t, logic signed [15:0] xr,
			logic signed [15:0] yr, logic signed [15:0] zr, logic fail);
		result_t     r;
		logic [31:0] elapsed;
		int          ax, ay, az, dx, dy, dz, clr;
		r.motion = trk_motion;
		r.status = STATUS_OK;
		r.sample_taken = 1'b0;
		elapsed = t - trk_time;
		if (lim_hyst >= lim_thr) begin
			r.status = STATUS_BAD_CFG;
			return r;
		end
		// too soon: skipped before the read flag is looked at
		if (trk_has_ref && lim_intv != 0 && elapsed < 32'(lim_intv))
			return r;
		if (fail) begin
			r.status = STATUS_READ_ERR;
			return r;
		end
		ax = to_mg(xr);
		ay = to_mg(yr);
		az = to_mg(zr);
		if (!trk_has_ref) begin
			trk_has_ref = 1'b1;
			trk_motion = 1'b0;
		end else begin
			dx = magnitude(ax - trk_x);
			dy = magnitude(ay - trk_y);
			dz = magnitude(az - trk_z);
			clr = lim_thr - lim_hyst;
			if (dx >= lim_thr || dy >= lim_thr || dz >= lim_thr)
				trk_motion = 1'b1;
			else if (dx < clr && dy < clr && dz < clr)
				trk_motion = 1'b0;
		end
		trk_x = ax;
		trk_y = ay;
		trk_z = az;
		trk_time = t;
		r.motion = trk_motion;
		r.sample_taken = 1'b1;
		return r;
	endfunction

	// Drive one sample beat, wait for acceptance, then record what must come out
	task automatic offer_sample(logic [31:0] t, logic [15:0] xr, logic [15:0] yr,
			logic [15:0] zr, logic fail, bit typed, result_t typed_exp);
		result_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stamp_ms <= t;
		x_raw <= xr;
		y_raw <= yr;
		z_raw <= zr;
		read_failed <= fail;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = judge_motion(t, xr, yr, zr, fail);
		motion_verdicts.push_back(typed ? typed_exp : predicted);
	endtask

	// Stop offering and wait until every expected beat has come out
	task automatic settle();
		in_valid <= 1'b0;
		while (motion_verdicts.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Write all registers plus the spare index; junk in the unused upper bits
	task automatic load_config(int thr, int hyst, int intv);
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= 16'(($urandom_range(0, 15) << ThrW) | (thr & 'hFFF));
		@(posedge clk);
		cfg_index <= REG_HYSTERESIS;
		cfg_wdata <= 16'(($urandom_range(0, 15) << ThrW) | (hyst & 'hFFF));
		@(posedge clk);
		cfg_index <= REG_INTERVAL;
		cfg_wdata <= 16'(intv);
		@(posedge clk);
		cfg_index <= RegSpare;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_thr = thr & 'hFFF;
		lim_hyst = hyst & 'hFFF;
		lim_intv = intv & 'hFFFF;
	endtask

	// Move an axis by a random amount scaled around the threshold
	function automatic int nudge(int base, int thr);
		int step;
		step = $urandom_range(0, thr + thr / 2 + 2) * 16 + $urandom_range(0, 16);
		if ($urandom_range(0, 1) == 1)
			step = -step;
		step = base + step;
		if (step > 32767)
			step = 32767;
		if (step < -32768)
			step = -32768;
		return step;
	endfunction

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_off_reqs != hold_off_seen) begin
			hold_off_seen <= hold_off_reqs;
			hold_left <= HoldOffCycles;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	task automatic report_mismatch(string what, result_t want);
		err_count++;
		if (err_count <= MaxReports)
			$display("%0t: %s: motion exp %b got %b, status exp %0d got %0d, taken exp %b got %b",
				$time, what, want.motion, motion, want.status, status,
				want.sample_taken, sample_taken);
	endtask

	// Result checker: every output beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (motion_verdicts.size() == 0)
				report_mismatch("result beat with nothing expected", '0);
			else if (motion !== motion_verdicts[0].motion ||
					status !== motion_verdicts[0].status ||
					sample_taken !== motion_verdicts[0].sample_taken)
				report_mismatch("result mismatch", motion_verdicts.pop_front());
			else
				void'(motion_verdicts.pop_front());
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		result_t     row_exp;
		logic [31:0] gen_time;
		int          gx, gy, gz, thr, hyst, intv, pick;
		logic [31:0] t;
		logic [15:0] xr, yr, zr;
		logic        fail;

		// thr, hyst, intv, time, x, y, z, fail, typed, motion, status, taken
		probes = '{
			// reset settings: read failure before any reference, then full-scale swings
			'{100, 20, 0, 32'd10, 16'h1234, 16'h5678, 16'h9ABC, 1'b1,
				1'b1, 1'b0, STATUS_READ_ERR, 1'b0},
			'{100, 20, 0, 32'd20, 16'h7FFF, 16'h8000, 16'h0000, 1'b0,
				1'b1, 1'b0, STATUS_OK, 1'b1},
			'{100, 20, 0, 32'd30, 16'h8000, 16'h7FFF, 16'h8000, 1'b0,
				1'b1, 1'b1, STATUS_OK, 1'b1},
			'{100, 20, 0, 32'd40, 16'h8000, 16'h7FFF, 16'h8000, 1'b0,
				1'b1, 1'b0, STATUS_OK, 1'b1},
			// just over threshold, then inside the hold band
			'{100, 20, 0, 32'd50, 16'h86A4, 16'h7FFF, 16'h8000, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 20, 0, 32'd60, 16'h80E5, 16'h7FFF, 16'h8000, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 20, 0, 32'd70, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			// small negatives truncate toward zero
			'{100, 20, 0, 32'd80, 16'hFFFF, 16'h0001, 16'hFFEF, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 20, 0, 32'd90, 16'h0000, 16'h0000, 16'h0000, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			// bad configuration wins over everything, including a failed read
			'{0, 0, 0, 32'd100, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{0, 0, 0, 32'd110, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{50, 50, 0, 32'd120, 16'h4000, 16'hC000, 16'h1000, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			// widest threshold, narrowest clear band
			'{4095, 4094, 0, 32'd130, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{4095, 4094, 0, 32'd140, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			// longest interval: too soon, too soon with failed read, wrap at boundary
			'{100, 99, 65535, 32'd141, 16'h0100, 16'h0100, 16'h0100, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 99, 65535, 32'd142, 16'h0100, 16'h0100, 16'h0100, 1'b1,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 99, 65535, 32'hFFFF_8000, 16'h0100, 16'h0200, 16'h0300, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 99, 65535, 32'h0000_7FFF, 16'h8000, 16'h0200, 16'h0300, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 99, 65535, 32'h0001_7FFD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{100, 99, 65535, 32'h0001_7FFE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			// smallest threshold and interval
			'{1, 0, 1, 32'h0000_7FFF, 16'h1111, 16'h2222, 16'h3333, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{1, 0, 1, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{1, 0, 1, 32'h0000_0000, 16'h8000, 16'h8000, 16'h8000, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0},
			'{4095, 0, 0, 32'h0000_0001, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0,
				1'b0, 1'b0, STATUS_OK, 1'b0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed probes; registers change only with the block drained
		foreach (probes[i]) begin
			if (probes[i].thr != lim_thr || probes[i].hyst != lim_hyst ||
					probes[i].intv != lim_intv) begin
				settle();
				load_config(probes[i].thr, probes[i].hyst, probes[i].intv);
			end
			row_exp.motion = probes[i].motion;
			row_exp.status = probes[i].status;
			row_exp.sample_taken = probes[i].taken;
			offer_sample(probes[i].t, probes[i].x, probes[i].y, probes[i].z,
				probes[i].fail, probes[i].typed, row_exp);
		end

		// Random phases: settings and idling change between phases
		gen_time = trk_time;
		gx = 0;
		gy = 0;
		gz = 0;
		for (int p = 0; p < NumPhases; p++) begin
			settle();
			case (p)
				1: begin thr = 4095; hyst = 0; intv = 65535; end
				2: begin thr = 1; hyst = 0; intv = 1; end
				3: begin
					thr = $urandom_range(0, 4095);
					hyst = $urandom_range(thr, 4095);
					intv = $urandom_range(0, 20);
				end
				4: begin thr = 100; hyst = 20; intv = 0; end
				default: begin
					thr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095)
						: $urandom_range(40, 400);
					hyst = $urandom_range(0, thr - 1);
					pick = $urandom_range(0, 2);
					intv = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 40)
						: $urandom_range(41, 65535);
				end
			endcase
			load_config(thr, hyst, intv);
			case (p % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 46; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 46; end
				default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
			endcase
			for (int n = 0; n < PhaseBeats; n++) begin
				// long receiver hold-off while beats keep coming
				if (p == 0 && n == 20)
					hold_off_reqs++;
				// sender pause until the pipe is empty
				if (p == 5 && n == 100)
					settle();
				if ($urandom_range(0, 9) == 0) begin
					// noise: anything the fields allow
					t = $urandom;
					xr = 16'($urandom);
					yr = 16'($urandom);
					zr = 16'($urandom);
					gen_time = t;
					gx = int'($signed(xr));
					gy = int'($signed(yr));
					gz = int'($signed(zr));
				end else begin
					gen_time = gen_time + ((lim_intv > 0) ? $urandom_range(0, 2 * lim_intv)
						: $urandom_range(0, 50));
					gx = nudge(gx, lim_thr);
					gy = nudge(gy, lim_thr);
					gz = nudge(gz, lim_thr);
					t = gen_time;
					xr = 16'(gx);
					yr = 16'(gy);
					zr = 16'(gz);
				end
				fail = ($urandom_range(0, 19) == 0);
				offer_sample(t, xr, yr, zr, fail, 1'b0, '0);
			end
		end

		settle();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
